// ===== hw/rtl/ipv4hb_pkg.sv =====
// shared constants and types of the ipv4 header builder and fragmenter
package ipv4hb_pkg;

  localparam int MAX_PAYLOAD_DEF = 8192;
  localparam int MAX_PIECES      = 64;
  localparam int PIECE_CNT_W     = $clog2(MAX_PIECES);

  localparam logic [15:0] MTU_MIN     = 16'd148;
  localparam logic [15:0] MTU_RESET   = 16'd1500;
  localparam logic [15:0] HDR_BYTES   = 16'd20;
  localparam logic [15:0] VER_IHL_TOS = 16'h4500;
  localparam logic [15:0] PIECE_MASK  = 16'hFFF8;

  localparam logic CFG_IDX_MTU  = 1'b0;
  localparam logic CFG_IDX_ADDR = 1'b1;

  typedef struct packed {
    logic clear;
    logic restore;
    logic add;
    logic save;
  } csum_ctrl_t;

endpackage

// ===== hw/rtl/ipv4hb_csum.sv =====
// ones-complement accumulator shared by all header words
module ipv4hb_csum
  import ipv4hb_pkg::*;
(
  input  logic        clk,
  input  csum_ctrl_t  ctrl,
  input  logic [15:0] word,
  output logic [15:0] checksum
);

  logic [15:0] sum_r;
  logic [15:0] part_r;
  logic [16:0] raw;
  logic [15:0] fold;

  assign raw      = {1'b0, sum_r} + {1'b0, word};
  assign fold     = raw[15:0] + {15'd0, raw[16]};
  assign checksum = ~sum_r;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      sum_r <= '0;
    end else if (ctrl.restore) begin
      sum_r <= part_r;
    end else if (ctrl.add) begin
      sum_r <= fold;
    end
    if (ctrl.add && ctrl.save) begin
      part_r <= fold;
    end
  end

endmodule

// ===== hw/rtl/ipv4_header_builder_fragmenter.sv =====
// top level of the ipv4 header builder and fragmenter
// usage:
//   in_* takes one packet descriptor word; out_* gives one ipv4 header word per
//   fragment, out_tlast marking the final header of a descriptor. a descriptor
//   with ttl zero is taken and gives no header.
//   cfg_we writes the interface mtu (index 0) or interface address (index 1).
// timing:
//   the checksum is built by one 16-bit end-around-carry adder, one header word
//   a cycle. the first header of a descriptor is built in setup, piece, nine
//   adds and load; each further fragment in piece, three adds and load,
//   because the invariant words are summed once. in_tready is high only while
//   no descriptor is in work.
// reset:
//   mtu returns to 1500, address and the ident counter to zero, no word pending.
// stall:
//   a finished header waits in the output register; the next fragment is built
//   meanwhile and held until the register frees. after the last header is
//   loaded a new descriptor can be accepted while that header still waits.
module ipv4_header_builder_fragmenter
  import ipv4hb_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // payload_length, source_in, dest_address, protocol, ttl, offset_base,
  // more_in, ident_in, last_flag_in, direct_broadcast, gateway, zero pad
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // total_length, ident, more_fragments, fragment_offset, source_address,
  // header_checksum, data_start, next_hop, broadcast_send, zero pad
  output logic [143:0] out_tdata,
  output logic         out_tlast
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_PIECE = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;

  localparam logic [3:0] W_VER     = 4'd0;
  localparam logic [3:0] W_TTL     = 4'd1;
  localparam logic [3:0] W_SRC_HI  = 4'd2;
  localparam logic [3:0] W_SRC_LO  = 4'd3;
  localparam logic [3:0] W_DST_HI  = 4'd4;
  localparam logic [3:0] W_DST_LO  = 4'd5;
  localparam logic [3:0] W_TLEN    = 4'd6;
  localparam logic [3:0] W_ID      = 4'd7;
  localparam logic [3:0] W_FLAGOFF = 4'd8;

  localparam logic [PIECE_CNT_W-1:0] N_LAST = PIECE_CNT_W'(MAX_PIECES - 1);

  // input word fields
  logic [13:0] in_len;
  logic [31:0] in_src;
  logic [31:0] in_dst;
  logic [7:0]  in_proto;
  logic [7:0]  in_ttl;
  logic [12:0] in_base;
  logic        in_more;
  logic [15:0] in_idin;
  logic        in_lastf;
  logic        in_bc;
  logic [31:0] in_gw;

  assign in_len   = in_tdata[13:0];
  assign in_src   = in_tdata[45:14];
  assign in_dst   = in_tdata[77:46];
  assign in_proto = in_tdata[85:78];
  assign in_ttl   = in_tdata[93:86];
  assign in_base  = in_tdata[106:94];
  assign in_more  = in_tdata[107];
  assign in_idin  = in_tdata[123:108];
  assign in_lastf = in_tdata[124];
  assign in_bc    = in_tdata[125];
  assign in_gw    = in_tdata[157:126];

  logic [2:0]  state_r;
  logic [15:0] mtu_r;
  logic [31:0] addr_r;
  logic [15:0] ident_cnt_r;

  logic [13:0] len_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [7:0]  proto_r;
  logic [7:0]  ttl_r;
  logic [12:0] base_r;
  logic        more_r;
  logic [15:0] idin_r;
  logic        lastf_r;
  logic        bc_r;
  logic [31:0] hop_r;

  logic [15:0] piece_r;
  logic        frag_r;
  logic [15:0] id_r;
  logic [13:0] x_r;
  logic [PIECE_CNT_W-1:0] n_r;
  logic [15:0] tlen_r;
  logic [12:0] off_r;
  logic        mf_r;
  logic        last_r;
  logic [3:0]  step_r;

  logic        out_tvalid_r;
  logic        out_last_r;
  logic [13:0] o_tlen_r;
  logic [15:0] o_id_r;
  logic        o_mf_r;
  logic [12:0] o_off_r;
  logic [31:0] o_src_r;
  logic [15:0] o_csum_r;
  logic [12:0] o_start_r;
  logic [31:0] o_hop_r;
  logic        o_bc_r;

  logic        in_acc;
  logic        load_ok;
  logic [13:0] len_sat;
  logic [15:0] mtu_eff;
  logic        fits;
  logic [13:0] rem;
  logic        fin_c;
  logic [13:0] y_c;
  logic [15:0] word;
  logic [15:0] checksum;
  csum_ctrl_t  cctl;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign load_ok   = (state_r == ST_LOAD) && (!out_tvalid_r || out_tready);

  assign len_sat = ({3'd0, in_len} > 17'(MAX_PAYLOAD)) ? 14'(MAX_PAYLOAD) : in_len;
  assign mtu_eff = (mtu_r < MTU_MIN) ? MTU_MIN : mtu_r;
  assign fits    = ({3'd0, len_r} + {1'b0, HDR_BYTES}) <= {1'b0, mtu_eff};

  assign rem   = len_r - x_r;
  assign fin_c = !frag_r || ({2'd0, rem} <= piece_r);
  assign y_c   = fin_c ? rem : piece_r[13:0];

  always_comb begin
    case (step_r)
      W_VER:     word = VER_IHL_TOS;
      W_TTL:     word = {ttl_r, proto_r};
      W_SRC_HI:  word = src_r[31:16];
      W_SRC_LO:  word = src_r[15:0];
      W_DST_HI:  word = dst_r[31:16];
      W_DST_LO:  word = dst_r[15:0];
      W_TLEN:    word = tlen_r;
      W_ID:      word = id_r;
      W_FLAGOFF: word = {2'd0, mf_r, off_r};
      default:   word = '0;
    endcase
  end

  always_comb begin
    cctl.clear   = (state_r == ST_PIECE) && (n_r == '0);
    cctl.restore = (state_r == ST_PIECE) && (n_r != '0);
    cctl.add     = (state_r == ST_SUM);
    cctl.save    = (step_r == W_DST_LO);
  end

  ipv4hb_csum u_csum (
    .clk      (clk),
    .ctrl     (cctl),
    .word     (word),
    .checksum (checksum)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mtu_r        <= MTU_RESET;
      addr_r       <= '0;
      ident_cnt_r  <= '0;
      out_tvalid_r <= 1'b0;
      n_r          <= '0;
      step_r       <= W_VER;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDX_MTU:  mtu_r  <= cfg_wdata[15:0];
          CFG_IDX_ADDR: addr_r <= cfg_wdata;
          default:      ;
        endcase
      end
      if (load_ok) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_ttl != 8'd0)) begin
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          n_r <= '0;
          if (fits && (base_r == 13'd0) && !more_r) begin
            ident_cnt_r <= ident_cnt_r + 16'd1;
          end
          state_r <= ST_PIECE;
        end
        ST_PIECE: begin
          step_r  <= (n_r == '0) ? W_VER : W_TLEN;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          if (step_r == W_FLAGOFF) begin
            state_r <= ST_LOAD;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        ST_LOAD: begin
          if (load_ok) begin
            if (last_r) begin
              state_r <= ST_IDLE;
            end else begin
              n_r     <= n_r + 1'b1;
              state_r <= ST_PIECE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // descriptor and header datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      len_r   <= len_sat;
      src_r   <= (in_src == 32'd0) ? addr_r : in_src;
      dst_r   <= in_dst;
      proto_r <= in_proto;
      ttl_r   <= in_ttl;
      base_r  <= in_base;
      more_r  <= in_more;
      idin_r  <= in_idin;
      lastf_r <= in_lastf;
      bc_r    <= in_bc;
      hop_r   <= in_bc ? 32'd0 : in_gw;
    end
    if (state_r == ST_SETUP) begin
      piece_r <= (mtu_eff - HDR_BYTES) & PIECE_MASK;
      frag_r  <= !fits;
      id_r    <= (fits && (base_r == 13'd0) && !more_r) ? ident_cnt_r : idin_r;
      x_r     <= '0;
    end
    if (state_r == ST_PIECE) begin
      tlen_r <= {2'd0, y_c} + HDR_BYTES;
      off_r  <= base_r + {2'd0, x_r[13:3]};
      mf_r   <= frag_r ? (!fin_c || lastf_r) : (more_r || lastf_r);
      last_r <= fin_c || (n_r == N_LAST);
    end
    if (load_ok) begin
      out_last_r <= last_r;
      o_tlen_r   <= tlen_r[13:0];
      o_id_r     <= id_r;
      o_mf_r     <= mf_r;
      o_off_r    <= off_r;
      o_src_r    <= src_r;
      o_csum_r   <= checksum;
      o_start_r  <= x_r[12:0];
      o_hop_r    <= hop_r;
      o_bc_r     <= bc_r;
      if (!last_r) begin
        x_r <= x_r + piece_r[13:0];
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, o_bc_r, o_hop_r, o_start_r, o_csum_r, o_src_r,
                       o_off_r, o_mf_r, o_id_r, o_tlen_r};

  a_frag_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PIECE && frag_r) |-> (x_r < len_r))
    else $error("fragment start beyond payload");

  a_ident_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (ident_cnt_r != $past(ident_cnt_r))) |-> ($past(state_r) == ST_SETUP))
    else $error("ident counter moved outside setup");

  a_whole_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load_ok && !frag_r) |-> last_r)
    else $error("unfragmented header not marked last");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_LOAD))
    else $error("output word raised outside load");

endmodule

// ===== bench/ipv4_header_builder_fragmenter_tb.sv =====
// testbench for the ipv4 header builder and fragmenter, self-checking against its own header predictor
module ipv4_header_builder_fragmenter_tb;
  import ipv4hb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [1:0]  pad;
    logic [31:0] gateway;
    logic        direct_broadcast;
    logic        last_flag;
    logic [15:0] ident_in;
    logic        more_in;
    logic [12:0] offset_base;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [31:0] dest;
    logic [31:0] source;
    logic [13:0] payload_length;
  } descriptor_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic        broadcast_send;
    logic [31:0] next_hop;
    logic [12:0] data_start;
    logic [15:0] checksum;
    logic [31:0] source;
    logic [12:0] frag_offset;
    logic        more_fragments;
    logic [15:0] ident;
    logic [13:0] total_length;
  } header_t;

  typedef struct packed {
    logic    last;
    header_t hdr;
  } expected_header_t;

  class header_ledger;
    logic [15:0] iface_mtu = MTU_RESET;
    logic [31:0] iface_address = '0;
    logic [15:0] ident_counter = '0;
    expected_header_t pending[$];
    int errors = 0;
    int headers_seen = 0;
    int dropped = 0;

    function void write_register(logic idx, logic [31:0] val);
      if (idx == CFG_IDX_MTU) iface_mtu = val[15:0];
      else iface_address = val;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function void push_header(int unsigned plen, logic [15:0] id, logic mf, int unsigned off,
                              logic [31:0] src, descriptor_t d, int unsigned start, logic last);
      logic [15:0] words[9];
      logic [31:0] s;
      logic [15:0] tlen;
      logic [12:0] off13;
      expected_header_t e;
      tlen = 16'(plen + HDR_BYTES);
      off13 = 13'(off);
      words = '{VER_IHL_TOS, tlen, id, {2'b00, mf, off13}, {d.ttl, d.protocol},
                src[31:16], src[15:0], d.dest[31:16], d.dest[15:0]};
      s = '0;
      foreach (words[k]) begin
        s = s + words[k];
        s = (s & 32'hFFFF) + (s >> 16);
      end
      e = '0;
      e.last = last;
      e.hdr.total_length = tlen[13:0];
      e.hdr.ident = id;
      e.hdr.more_fragments = mf;
      e.hdr.frag_offset = off13;
      e.hdr.source = src;
      e.hdr.checksum = ~s[15:0];
      e.hdr.data_start = 13'(start);
      e.hdr.next_hop = d.direct_broadcast ? 32'h0 : d.gateway;
      e.hdr.broadcast_send = d.direct_broadcast;
      pending.push_back(e);
    endfunction

    function void take_descriptor(descriptor_t d);
      int unsigned len, mtu, piece, x, y;
      int n;
      logic [31:0] src;
      logic fin;
      if (d.ttl == 0) begin
        dropped++;
        return;
      end
      len = 32'(d.payload_length);
      if (len > MAX_PAYLOAD_DEF) len = MAX_PAYLOAD_DEF;
      mtu = (iface_mtu < MTU_MIN) ? 32'(MTU_MIN) : 32'(iface_mtu);
      src = (d.source == 0) ? iface_address : d.source;
      if (len + HDR_BYTES <= mtu) begin
        if (d.offset_base == 0 && !d.more_in) begin
          push_header(len, ident_counter, d.last_flag, 0, src, d, 0, 1'b1);
          ident_counter++;
        end else begin
          push_header(len, d.ident_in, d.more_in | d.last_flag, d.offset_base, src, d, 0, 1'b1);
        end
        return;
      end
      piece = (mtu - HDR_BYTES) & PIECE_MASK;
      x = 0;
      n = 0;
      while (x < len && n < MAX_PIECES) begin
        y = (x + piece >= len) ? len - x : piece;
        fin = (x + y >= len);
        push_header(y, d.ident_in, !fin || d.last_flag, d.offset_base + (x >> 3), src, d, x,
                    fin || n == MAX_PIECES - 1);
        x += piece;
        n++;
      end
    endfunction

    function void match_field(string name, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        errors++;
        $display("[%0t] %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, seen);
      end
    endfunction

    function void check_header(header_t got, logic last);
      expected_header_t e;
      headers_seen++;
      if (pending.size() == 0) begin
        errors++;
        $display("[%0t] header with nothing expected: expected none, actual 0x%0h", $time, got);
        return;
      end
      e = pending.pop_front();
      match_field("total_length", e.hdr.total_length, got.total_length);
      match_field("ident", e.hdr.ident, got.ident);
      match_field("more_fragments", e.hdr.more_fragments, got.more_fragments);
      match_field("fragment_offset", e.hdr.frag_offset, got.frag_offset);
      match_field("source_address", e.hdr.source, got.source);
      match_field("header_checksum", e.hdr.checksum, got.checksum);
      match_field("data_start", e.hdr.data_start, got.data_start);
      match_field("next_hop", e.hdr.next_hop, got.next_hop);
      match_field("broadcast_send", e.hdr.broadcast_send, got.broadcast_send);
      match_field("last_piece", e.last, last);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [31:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // payload_length, source_in, dest_address, protocol, ttl, offset_base,
  // more_in, ident_in, last_flag_in, direct_broadcast, gateway, zero pad
  logic [159:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // total_length, ident, more_fragments, fragment_offset, source_address,
  // header_checksum, data_start, next_hop, broadcast_send, zero pad
  logic [143:0] out_tdata;
  logic         out_tlast;

  header_ledger ledger;
  int unsigned  eff_mtu = MTU_RESET;
  int           sent = 0;
  int           settings = 1;
  int           burst_left = 0;
  int           cycle_count = 0;
  bit           long_hold_req = 1'b0;
  bit           long_hold_done = 1'b0;
  int           hold_left = 0;
  int           rx_mode = 0;
  int           mode_left = 0;

  ipv4_header_builder_fragmenter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[%0t] timeout with %0d headers outstanding", $time, ledger.outstanding());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: one long hold-off, otherwise alternating ready patterns
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left <= 400;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_header(out_tdata, out_tlast);
  end

  task automatic cfg_write(logic idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    ledger.write_register(idx, val);
    if (idx == CFG_IDX_MTU) eff_mtu = (val[15:0] < MTU_MIN) ? 32'(MTU_MIN) : 32'(val[15:0]);
    @(posedge clk);
  endtask

  task automatic offer_descriptor(descriptor_t d);
    int gap;
    in_tdata <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    ledger.take_descriptor(d);
    sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // let every expected header drain, then allow for a dropped word still in work
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic descriptor_t random_descriptor();
    descriptor_t d;
    int unsigned len, piece;
    piece = (eff_mtu - 20) & 'hFFF8;
    case ($urandom_range(0, 9))
      0: len = $urandom_range(0, 16383);
      1, 2, 3: len = $urandom_range(0, 200);
      4, 5: len = eff_mtu - 28 + $urandom_range(0, 16);
      6, 7: len = $urandom_range(201, 3000);
      8: len = piece * $urandom_range(1, 4) + $urandom_range(0, 2) - 1;
      default: len = $urandom_range(8185, 16383);
    endcase
    if (len > 16383) len = $urandom_range(0, 16383);
    d = '0;
    d.payload_length = 14'(len);
    d.source = ($urandom_range(0, 5) == 0) ? 32'h0 : $urandom;
    d.dest = $urandom;
    d.protocol = 8'($urandom);
    d.ttl = ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    d.offset_base = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'($urandom_range(0, 8191));
    d.more_in = ($urandom_range(0, 3) == 0);
    d.ident_in = 16'($urandom);
    d.last_flag = ($urandom_range(0, 4) == 0);
    d.direct_broadcast = ($urandom_range(0, 3) == 0);
    d.gateway = $urandom;
    return d;
  endfunction

  initial begin
    descriptor_t d, plain;
    int unsigned mtu_set[6];
    logic [31:0] addr_set[6];
    ledger = new();
    mtu_set = '{148, 65535, 576, 100, 1500, 0};
    addr_set = '{$urandom, 32'h0, 32'hFFFF_FFFF, $urandom, $urandom, $urandom};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plain = '0;
    plain.payload_length = 14'd100;
    plain.source = 32'h0A00_0001;
    plain.dest = 32'hC0A8_0001;
    plain.protocol = 8'd17;
    plain.ttl = 8'd64;
    plain.ident_in = 16'h1234;
    plain.gateway = 32'h0A00_00FE;

    // reset settings: mtu 1500, interface address zero
    d = plain; d.payload_length = 14'd0; d.ttl = 8'd255; offer_descriptor(d);
    d = plain; d.payload_length = 14'd1480; offer_descriptor(d);
    d = plain; d.payload_length = 14'd1481; offer_descriptor(d);
    d = plain; d.payload_length = 14'd3000; d.ttl = 8'd0; offer_descriptor(d);
    d = plain; d.payload_length = 14'h3FFF; offer_descriptor(d);
    d = plain; d.payload_length = 14'd8192; offer_descriptor(d);
    d = plain; d.payload_length = 14'd4000; d.offset_base = 13'h1FFF; offer_descriptor(d);
    d = plain; d.more_in = 1'b1; offer_descriptor(d);
    d = plain; d.offset_base = 13'd37; offer_descriptor(d);
    d = plain; d.payload_length = 14'd3500; d.last_flag = 1'b1; offer_descriptor(d);
    d = plain; d.last_flag = 1'b1; offer_descriptor(d);
    d = plain; d.direct_broadcast = 1'b1; d.gateway = 32'hFFFF_FFFF; offer_descriptor(d);
    d = plain; d.source = 32'h0; offer_descriptor(d);
    d = plain; d.source = 32'hFFFF_FFFF; d.dest = 32'hFFFF_FFFF; d.protocol = 8'hFF;
    d.ident_in = 16'hFFFF; d.gateway = 32'hFFFF_FFFF; d.payload_length = 14'd2000;
    offer_descriptor(d);
    d = plain; d.payload_length = 14'd2960; offer_descriptor(d);
    d = plain; d.ttl = 8'd1; d.more_in = 1'b1; d.offset_base = 13'h1FFF; offer_descriptor(d);

    // mtu below the minimum, all-ones interface address
    drain_block();
    cfg_write(CFG_IDX_MTU, 32'h0);
    cfg_write(CFG_IDX_ADDR, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    settings++;
    d = plain; d.payload_length = 14'h3FFF; d.source = 32'h0; offer_descriptor(d);
    d = plain; d.payload_length = 14'd128; offer_descriptor(d);
    d = plain; d.payload_length = 14'd129; d.source = 32'h0; offer_descriptor(d);
    d = plain; d.payload_length = 14'd256; d.offset_base = 13'h1FF0; offer_descriptor(d);

    for (int p = 0; p < 6; p++) begin
      drain_block();
      cfg_write(CFG_IDX_MTU, (p == 5) ? $urandom_range(148, 9000) : mtu_set[p]);
      cfg_write(CFG_IDX_ADDR, addr_set[p]);
      cfg_we <= 1'b0;
      settings++;
      for (int i = 0; i < 58; i++) begin
        if (p == 0 && i == 6) long_hold_req = 1'b1;
        offer_descriptor(random_descriptor());
      end
    end

    in_tvalid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d descriptors (%0d dropped for zero ttl) giving %0d headers",
             sent, ledger.dropped, ledger.headers_seen);
    $display("across %0d mtu and address settings, with one long output stall", settings);
    if (ledger.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== ipv4_header_builder_fragmenter.f =====
hw/rtl/ipv4hb_pkg.sv
hw/rtl/ipv4hb_csum.sv
hw/rtl/ipv4_header_builder_fragmenter.sv
bench/ipv4_header_builder_fragmenter_tb.sv
